### sv/mlf_pkg.sv
// Package for the MAC learning forwarder: field widths, header limits,
// verdict codes and the request and response structs of the address table.
// No dependencies.
package mlf_pkg;

  localparam int unsigned MacW          = 48;
  localparam int unsigned PortFieldW    = 8;
  localparam int unsigned LenW          = 16;
  localparam int unsigned GroupBit      = 40;
  localparam logic [LenW-1:0] MinFrameBytes = 16'd14;

  localparam int unsigned InDataW  = 120;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [1:0] {
    VerdictForward   = 2'd0,
    VerdictDrop      = 2'd1,
    VerdictBroadcast = 2'd2
  } verdict_e;

  typedef struct packed {
    logic            commit;
    logic            learn;
    logic [MacW-1:0] src_mac;
    logic [MacW-1:0] dst_mac;
  } cam_req_t;

  typedef struct packed {
    logic src_ok;
    logic dst_hit;
  } cam_rsp_t;

endpackage

### sv/mlf_cam.sv
// Associative address table for the MAC learning forwarder, held in flops.
// Compares both addresses against every entry, learns the source, returns the
// destination's port. Depends on mlf_pkg.
module mlf_cam
  import mlf_pkg::*;
#(
  parameter int unsigned ENTRIES   = 256,
  parameter int unsigned PORT_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cam_req_t             req_i,
  input  logic [PORT_BITS-1:0] port_i,
  output cam_rsp_t             rsp_o,
  output logic [PORT_BITS-1:0] port_o
);

  logic [ENTRIES-1:0]   valid_q;
  logic [MacW-1:0]      addr_q [ENTRIES];
  logic [PORT_BITS-1:0] port_q [ENTRIES];

  logic [ENTRIES-1:0]   src_hit;
  logic [ENTRIES-1:0]   dst_hit;
  logic [ENTRIES-1:0]   free_v;
  logic [ENTRIES-1:0]   free_oh;
  logic [ENTRIES-1:0]   wr_vec;
  logic [PORT_BITS-1:0] dst_port [ENTRIES];
  logic [PORT_BITS-1:0] dst_port_or;
  logic                 src_any;
  logic                 src_ok;
  logic                 wr_en;
  logic                 self_hit;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cmp
    assign src_hit[i]  = valid_q[i] && (addr_q[i] == req_i.src_mac);
    assign dst_hit[i]  = valid_q[i] && (addr_q[i] == req_i.dst_mac);
    assign free_v[i]   = !valid_q[i];
    assign dst_port[i] = dst_hit[i] ? port_q[i] : '0;
  end

  assign free_oh = free_v & (~free_v + {{(ENTRIES-1){1'b0}}, 1'b1});
  assign src_any = |src_hit;
  assign src_ok  = src_any || (|free_v);
  assign wr_vec  = src_any ? src_hit : free_oh;
  assign wr_en   = req_i.commit && req_i.learn && src_ok;

  always_comb begin
    dst_port_or = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      dst_port_or = dst_port_or | dst_port[i];
    end
  end

  assign self_hit      = req_i.learn && src_ok && (req_i.dst_mac == req_i.src_mac);
  assign rsp_o.src_ok  = src_ok;
  assign rsp_o.dst_hit = self_hit || (|dst_hit);
  assign port_o        = self_hit ? port_i : dst_port_or;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q <= valid_q | wr_vec;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_entry
    always_ff @(posedge clk_i) begin
      if (wr_en && wr_vec[i]) begin
        addr_q[i] <= req_i.src_mac;
        port_q[i] <= port_i;
      end
    end
  end

  a_src_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(src_hit))
    else $error("source address held in more than one entry");

  a_dst_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(dst_hit))
    else $error("destination address held in more than one entry");

  a_wr_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> $onehot(wr_vec))
    else $error("learning write does not select exactly one entry");

  a_learn_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (valid_q & $past(wr_vec)) == $past(wr_vec))
    else $error("learned entry not valid after the write");

endmodule

### sv/mac_learning_forwarder.sv
// Top level of the MAC learning forwarder: stream ports, input and result
// registers, and the verdict logic. Depends on mlf_pkg and mlf_cam.
//
// Each input word carries one frame header and produces exactly one result
// word. A header is taken into the input register, then learned and looked up
// against the whole address table combinationally, and its verdict lands in
// the result register. A new word can be taken every cycle when the output is
// not stalled; each header goes through the input register and then the
// result register. While a finished result waits, one more header can be
// taken into an empty input register. After that the input stalls until the
// result is taken.
// The table of TABLE_ENTRIES entries lives in flops with a valid bit each, so
// reset clears it at once and no clearing pass is needed. Headers see the
// table exactly as left by the header before them.
module mac_learning_forwarder
  import mlf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned PORT_BITS     = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // dst_mac[47:0], src_mac[95:48], rx_port[103:96], frame_length[119:104]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // verdict[1:0], out_port[9:2], zero fill[15:10]
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic                  in_valid_q;
  logic [MacW-1:0]       dst_q;
  logic [MacW-1:0]       src_q;
  logic [PortFieldW-1:0] ing_q;
  logic [LenW-1:0]       len_q;

  logic                  out_valid_q;
  verdict_e              verdict_q, verdict_d;
  logic [PortFieldW-1:0] oport_q, oport_d;

  logic                  proc;
  logic                  short_frame;
  cam_req_t              cam_req;
  cam_rsp_t              cam_rsp;
  logic [PORT_BITS-1:0]  port_in;
  logic [PORT_BITS-1:0]  port_hit;
  logic [PORT_BITS+PortFieldW-1:0] port_in_ext;
  logic [PORT_BITS+PortFieldW-1:0] port_out_ext;

  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      dst_q <= s_axis_tdata[47:0];
      src_q <= s_axis_tdata[95:48];
      ing_q <= s_axis_tdata[103:96];
      len_q <= s_axis_tdata[119:104];
    end
  end

  assign port_in_ext = {{PORT_BITS{1'b0}}, ing_q};
  assign port_in     = port_in_ext[PORT_BITS-1:0];
  assign short_frame = len_q < MinFrameBytes;

  assign cam_req.commit  = proc;
  assign cam_req.learn   = !short_frame && !src_q[GroupBit];
  assign cam_req.src_mac = src_q;
  assign cam_req.dst_mac = dst_q;

  mlf_cam #(
    .ENTRIES  (TABLE_ENTRIES),
    .PORT_BITS(PORT_BITS)
  ) u_cam (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (cam_req),
    .port_i(port_in),
    .rsp_o (cam_rsp),
    .port_o(port_hit)
  );

  assign port_out_ext = {{PortFieldW{1'b0}}, port_hit};

  always_comb begin
    verdict_d = VerdictDrop;
    oport_d   = '0;
    if (short_frame) begin
      verdict_d = VerdictDrop;
    end else if (cam_req.learn && !cam_rsp.src_ok) begin
      verdict_d = VerdictDrop;
    end else if (dst_q[GroupBit]) begin
      verdict_d = VerdictBroadcast;
    end else if (cam_rsp.dst_hit) begin
      verdict_d = VerdictForward;
      oport_d   = port_out_ext[PortFieldW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= proc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      verdict_q <= verdict_d;
      oport_q   <= oport_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, oport_q, verdict_q};

  a_port_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (verdict_q != VerdictForward) |-> oport_q == '0)
    else $error("egress port not zero on a drop or broadcast word");

  a_proc_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_q)
    else $error("processed header left no result word");

  a_in_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !proc |=> in_valid_q && $stable(dst_q) && $stable(src_q))
    else $error("waiting header lost or changed");

  a_short_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && short_frame |=> verdict_q == VerdictDrop)
    else $error("short frame not dropped");

endmodule

### sim/mlf_bridge_checker.sv
// Checker for the MAC learning forwarder: watches both streams, keeps its own
// copy of the address table, predicts each verdict and compares the results.
// Depends on mlf_pkg.
module mlf_bridge_checker
  import mlf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // dst_mac[47:0], src_mac[95:48], rx_port[103:96], frame_length[119:104]
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // verdict[1:0], out_port[9:2], zero fill[15:10]
  input  logic [OutDataW-1:0] m_axis_tdata,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PrintLimit = 40;

  typedef struct packed {
    logic [LenW-1:0]       frame_length;
    logic [PortFieldW-1:0] rx_port;
    logic [MacW-1:0]       src_mac;
    logic [MacW-1:0]       dst_mac;
  } frame_hdr_t;

  typedef struct packed {
    logic [5:0]            fill;
    logic [PortFieldW-1:0] out_port;
    verdict_e              verdict;
  } fwd_word_t;

  logic                  station_valid [TABLE_ENTRIES];
  logic [MacW-1:0]       station_mac   [TABLE_ENTRIES];
  logic [PortFieldW-1:0] station_port  [TABLE_ENTRIES];
  fwd_word_t             verdict_q [$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count_o < PrintLimit) begin
      $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    end
    fail_count_o++;
  endtask

  function automatic int find_station(input logic [MacW-1:0] mac);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (station_valid[i] && station_mac[i] == mac) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int find_free_entry();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!station_valid[i]) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Learns the source, then resolves the destination against the updated table.
  function automatic fwd_word_t learn_and_forward(input frame_hdr_t hdr);
    fwd_word_t res;
    int        idx;
    res = '{fill: '0, out_port: '0, verdict: VerdictDrop};
    if (hdr.frame_length < MinFrameBytes) begin
      return res;
    end
    if (!hdr.src_mac[GroupBit]) begin
      idx = find_station(hdr.src_mac);
      if (idx < 0) begin
        idx = find_free_entry();
        if (idx < 0) begin
          return res;
        end
        station_valid[idx] = 1'b1;
        station_mac[idx]   = hdr.src_mac;
      end
      station_port[idx] = hdr.rx_port;
    end
    if (hdr.dst_mac[GroupBit]) begin
      res.verdict = VerdictBroadcast;
      return res;
    end
    idx = find_station(hdr.dst_mac);
    if (idx >= 0) begin
      res.verdict  = VerdictForward;
      res.out_port = station_port[idx];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fwd_word_t got;
    fwd_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        station_valid[i] = 1'b0;
      end
      verdict_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = fwd_word_t'(m_axis_tdata);
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected result word", 64'(m_axis_tdata), '0);
        end else begin
          want = verdict_q.pop_front();
          if (got.verdict !== want.verdict) begin
            report_mismatch("verdict", 64'(got.verdict), 64'(want.verdict));
          end
          if (got.out_port !== want.out_port) begin
            report_mismatch("out_port", 64'(got.out_port), 64'(want.out_port));
          end
          if (got.fill !== want.fill) begin
            report_mismatch("zero fill", 64'(got.fill), 64'(want.fill));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        verdict_q.push_back(learn_and_forward(frame_hdr_t'(s_axis_tdata)));
      end
      pending_o <= verdict_q.size();
    end
  end

endmodule

### sim/tb_top.sv
// Testbench top for the MAC learning forwarder: clock, reset, header stimulus,
// result backpressure, watchdog and final verdict.
// Depends on mlf_pkg, mac_learning_forwarder and mlf_bridge_checker.
module tb_top;
  import mlf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned PoolSize     = 320;
  localparam int unsigned NarrowPool   = 48;
  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned HoldAfter    = 400;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 10;

  localparam logic [MacW-1:0] MacA     = 48'h0200_0000_0001;
  localparam logic [MacW-1:0] MacB     = 48'h0a1b_2c3d_4e5f;
  localparam logic [MacW-1:0] MacC     = 48'h3c00_dead_beef;
  localparam logic [MacW-1:0] MacGroup = 48'h0100_5e00_0001;
  localparam logic [MacW-1:0] MacOnes  = 48'hffff_ffff_ffff;
  localparam logic [MacW-1:0] MacZero  = 48'h0000_0000_0000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int          fail_count;
  int          words_pending;
  int          idle_cycles = 0;
  bit          no_idle     = 1'b0;
  logic [MacW-1:0] mac_pool [PoolSize];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  mac_learning_forwarder #(
    .TABLE_ENTRIES(TableEntries),
    .PORT_BITS    (PortFieldW)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  mlf_bridge_checker #(
    .TABLE_ENTRIES(TableEntries)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .fail_count_o(fail_count),
    .pending_o   (words_pending)
  );

  function automatic logic [MacW-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[MacW-1:0];
  endfunction

  task automatic send_header(input logic [MacW-1:0] dst, input logic [MacW-1:0] src,
                             input logic [PortFieldW-1:0] port,
                             input logic [LenW-1:0] len);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(0, 3));
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, port, src, dst};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Mostly addresses from the station pool so that learning and lookups hit,
  // with some group addresses, unknown addresses and short frames mixed in.
  task automatic send_random_header(input int unsigned pool_span);
    logic [MacW-1:0] dst;
    logic [MacW-1:0] src;
    logic [LenW-1:0] len;
    int unsigned     roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      dst = mac_pool[$urandom_range(0, pool_span - 1)];
    end else if (roll < 82) begin
      dst = rand_mac();
      dst[GroupBit] = 1'b1;
    end else begin
      dst = rand_mac();
    end
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      src = mac_pool[$urandom_range(0, pool_span - 1)];
    end else if (roll < 90) begin
      src = rand_mac();
      src[GroupBit] = 1'b1;
    end else begin
      src = rand_mac();
    end
    roll = $urandom_range(0, 99);
    if (roll < 88) begin
      len = LenW'($urandom_range(MinFrameBytes, 1518));
    end else if (roll < 94) begin
      len = LenW'($urandom_range(0, MinFrameBytes - 1));
    end else begin
      len = LenW'($urandom_range(0, 65535));
    end
    send_header(dst, src, PortFieldW'($urandom_range(0, 255)), len);
  endtask

  initial begin : header_source
    for (int i = 0; i < PoolSize; i++) begin
      mac_pool[i] = rand_mac();
      mac_pool[i][GroupBit] = 1'b0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_header(MacA, MacA, 8'd1, 16'd0);
    send_header(MacA, MacA, 8'd2, MinFrameBytes - 16'd1);
    send_header(MacA, MacA, 8'd0, MinFrameBytes);
    send_header(MacA, MacB, 8'd255, 16'hffff);
    send_header(MacB, MacA, 8'd7, 16'd64);
    send_header(MacA, MacA, 8'd9, 16'd64);
    send_header(MacC, MacB, 8'd3, 16'd1518);
    send_header(MacGroup, MacA, 8'd4, 16'd60);
    send_header(MacOnes, MacA, 8'd5, 16'd60);
    send_header(MacA, MacGroup, 8'd6, 16'd60);
    send_header(MacA, MacOnes, 8'd8, 16'd60);
    send_header(MacOnes, MacOnes, 8'd10, 16'd60);
    send_header(MacZero, MacZero, 8'h5a, 16'd60);
    send_header(MacB, MacZero, 8'ha5, 16'd60);
    send_header(MacGroup, MacOnes, 8'd11, MinFrameBytes - 16'd1);
    send_header(MacC, MacC, 8'd12, 16'd15);

    for (int i = 0; i < 900; i++) begin
      if (i % 150 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      send_random_header(NarrowPool);
    end
    // The wider pool holds more stations than the table, so it fills up.
    for (int i = 0; i < 940; i++) begin
      if (i % 150 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      send_random_header(PoolSize);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (words_pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS mac_learning_forwarder");
    end else begin
      $display("FAIL mac_learning_forwarder");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (taken == HoldAfter) begin
        stall = HoldCycles;
      end
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL mac_learning_forwarder");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### filelist.f
sv/mlf_pkg.sv
sv/mlf_cam.sv
sv/mac_learning_forwarder.sv
sim/mlf_bridge_checker.sv
sim/tb_top.sv
